### src/wpm_pkg.sv
package wpm_pkg;

  // Input modes as they arrive on the input channel
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_BYTE = 2'd1;
  localparam logic [1:0] MODE_END  = 2'd2;

  // Pattern element kinds; the spare code is taken as a literal
  localparam logic [1:0] KIND_LITERAL = 2'd0;
  localparam logic [1:0] KIND_ONE     = 2'd1;
  localparam logic [1:0] KIND_RUN     = 2'd2;

  // Depth of the queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] elem_kind;
    logic [7:0] elem_char;
    logic       pattern_last;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } out_item_t;

  // Operation carried from front to back
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_BYTE,
    OP_END
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       is_run;
    logic       is_one;
    logic [7:0] ch;
    logic       last;
  } op_t;

  // Front to queue control
  typedef struct packed {
    logic push;
    op_t  data;
  } push_t;

  // Queue to back control
  typedef struct packed {
    logic valid;
    op_t  data;
  } head_t;

endpackage

### src/wpm_front.sv
module wpm_front (
  input  logic              in_valid_i,
  input  wpm_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              in_stall_o,
  output wpm_pkg::push_t    push_o
);
  import wpm_pkg::*;

  // Stall only on a full queue
  assign in_stall_o = q_full_i;

  // Classify the item; unused mode is dropped here
  always_comb begin
    push_o.data.ch     = in_item_i.elem_char;
    push_o.data.last   = in_item_i.pattern_last;
    push_o.data.is_run = (in_item_i.elem_kind == KIND_RUN);
    push_o.data.is_one = (in_item_i.elem_kind == KIND_ONE);
    push_o.data.op     = OP_LOAD;
    push_o.push        = 1'b0;
    case (in_item_i.mode)
      MODE_LOAD: begin
        push_o.data.op = OP_LOAD;
        push_o.push    = in_valid_i && !q_full_i;
      end
      MODE_BYTE: begin
        push_o.data.op = OP_BYTE;
        push_o.push    = in_valid_i && !q_full_i;
      end
      MODE_END: begin
        push_o.data.op = OP_END;
        push_o.push    = in_valid_i && !q_full_i;
      end
      default: begin
        push_o.push = 1'b0;
      end
    endcase
  end

endmodule

### src/wpm_queue.sv
module wpm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wpm_pkg::push_t push_i,
  input  logic           pop_i,
  output logic           full_o,
  output wpm_pkg::head_t head_o
);
  import wpm_pkg::*;

  op_t               mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_pop;

  assign full_o       = (cnt_q == QCNT_W'(QDEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.data  = mem_q[rd_q];
  assign do_pop       = pop_i && head_o.valid;

  // Pointer and fill count update
  always_comb begin
    wr_d  = push_i.push ? wr_q + QPTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (push_i.push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!push_i.push && do_pop) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_q] <= push_i.data;
    end
  end

endmodule

### src/wpm_back.sv
module wpm_back #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wpm_pkg::head_t     head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wpm_pkg::out_item_t out_item_o
);
  import wpm_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IDX_W = $clog2(MAX_PATTERN);
  localparam int unsigned LVL   = $clog2(MAX_PATTERN + 1);

  // Pattern store, one lane per position
  logic [7:0]             char_q [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] run_q;
  logic [MAX_PATTERN-1:0] one_q;

  logic [LEN_W-1:0]     len_q, len_d;
  logic                 loading_q, loading_d;
  logic                 ovf_q, ovf_d;
  logic [MAX_PATTERN:0] start_q, start_d;
  logic [MAX_PATTERN:0] active_q, active_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  logic                   slot_ok;
  logic                   pop_load;
  logic                   pop_end;
  logic [MAX_PATTERN-1:0] lane_en;
  logic [MAX_PATTERN:0]   len_mask;
  logic [MAX_PATTERN:0]   step_raw;
  logic [MAX_PATTERN:0]   step_prop;
  logic [MAX_PATTERN:0]   gen_l  [LVL+1];
  logic [MAX_PATTERN:0]   prop_l [LVL+1];
  logic [LEN_W-1:0]       ld_pos;
  logic                   ld_fits;
  logic [MAX_PATTERN:0]   ld_base;

  // A result needs a free output slot; other ops always drain
  assign slot_ok  = !out_valid_q || !out_stall_i;
  assign pop_o    = head_i.valid && ((head_i.data.op != OP_END) || slot_ok);
  assign pop_load = pop_o && (head_i.data.op == OP_LOAD);
  assign pop_end  = pop_o && (head_i.data.op == OP_END);

  // Positions inside the current pattern
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      lane_en[i] = (LEN_W'(i) < len_q);
    end
    for (int i = 0; i <= MAX_PATTERN; i++) begin
      len_mask[i] = (LEN_W'(i) <= len_q);
    end
  end

  // Per-lane advance on one subject byte
  always_comb begin
    step_raw  = '0;
    step_prop = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      step_prop[i+1] = lane_en[i] && run_q[i];
      if (active_q[i] && lane_en[i]) begin
        if (run_q[i]) begin
          step_raw[i] = 1'b1;
        end else if (one_q[i] || (char_q[i] == head_i.data.ch)) begin
          step_raw[i+1] = 1'b1;
        end
      end
    end
  end

  // Closure over runs as a parallel prefix
  always_comb begin
    gen_l[0]  = step_raw;
    prop_l[0] = step_prop;
    for (int l = 0; l < LVL; l++) begin
      for (int i = 0; i <= MAX_PATTERN; i++) begin
        if (i >= (1 << l)) begin
          gen_l[l+1][i]  = gen_l[l][i] | (prop_l[l][i] & gen_l[l][i - (1 << l)]);
          prop_l[l+1][i] = prop_l[l][i] & prop_l[l][i - (1 << l)];
        end else begin
          gen_l[l+1][i]  = gen_l[l][i];
          prop_l[l+1][i] = prop_l[l][i];
        end
      end
    end
  end

  // Load position; a new pattern starts at zero
  assign ld_pos  = loading_q ? len_q : '0;
  assign ld_fits = (ld_pos < LEN_W'(MAX_PATTERN));
  assign ld_base = loading_q ? start_q : (MAX_PATTERN + 1)'(1);

  // Control and result update
  always_comb begin
    len_d       = len_q;
    loading_d   = loading_q;
    ovf_d       = ovf_q;
    start_d     = start_q;
    active_d    = active_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) begin
      unique case (head_i.data.op)
        OP_LOAD: begin
          start_d = ld_base;
          if (ld_fits) begin
            start_d[ld_pos + LEN_W'(1)] = ld_base[ld_pos] && head_i.data.is_run;
            len_d = ld_pos + LEN_W'(1);
          end else begin
            len_d = ld_pos;
          end
          ovf_d     = (loading_q && ovf_q) || !ld_fits;
          loading_d = !head_i.data.last;
          active_d  = start_d;
        end
        OP_BYTE: begin
          loading_d = 1'b0;
          active_d  = gen_l[LVL];
        end
        OP_END: begin
          loading_d              = 1'b0;
          out_d.matched          = !ovf_q && active_q[len_q];
          out_d.pattern_overflow = ovf_q;
          out_valid_d            = 1'b1;
          active_d               = start_q;
        end
        default: begin
          loading_d = loading_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      loading_q   <= 1'b0;
      ovf_q       <= 1'b0;
      start_q     <= (MAX_PATTERN + 1)'(1);
      active_q    <= (MAX_PATTERN + 1)'(1);
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      loading_q   <= loading_d;
      ovf_q       <= ovf_d;
      start_q     <= start_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Pattern store write
  always_ff @(posedge clk_i) begin
    if (pop_load && ld_fits) begin
      char_q[ld_pos[IDX_W-1:0]] <= head_i.data.ch;
      run_q[ld_pos[IDX_W-1:0]]  <= head_i.data.is_run;
      one_q[ld_pos[IDX_W-1:0]]  <= head_i.data.is_one;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  a_start_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q[0])
    else $error("start position lost");

  a_active_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q & ~len_mask) == '0)
    else $error("active position beyond pattern length");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_end |=> out_valid_q)
    else $error("end marker produced no result");

  a_ovf_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.pattern_overflow) |-> !out_q.matched)
    else $error("overflowed pattern reported a match");

endmodule

### src/wildcard_pattern_match.sv
// A result is registered: its end marker passes through the queue and then the result register.
// Throughput: one item per cycle; every subject byte updates all pattern positions at once
// through a parallel prefix over runs, so the back end retires one queued item each cycle,
// unless an end marker waits on a stalled output. Input stalls only when the four-entry queue
// between front and back is full. Reset: empty pattern, no overflow, start position active, queue and output empty.
module wildcard_pattern_match #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  wpm_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wpm_pkg::out_item_t out_item_o
);
  import wpm_pkg::*;

  push_t push;
  head_t head;
  logic  q_full;
  logic  pop;

  // Front: accept and classify
  wpm_front u_front (
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push)
  );

  // Queue between front and back
  wpm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  // Back: pattern store, active positions, result register
  wpm_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
